// File: hw/rtl/dual_pressure_limit_monitor_unit_defines.svh
// Assertion macros used by the checker file of the pressure monitor.
`ifndef DUAL_PRESSURE_LIMIT_MONITOR_UNIT_DEFINES_SVH
`define DUAL_PRESSURE_LIMIT_MONITOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPLM_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPLM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dplm_pkg.sv
package dplm_pkg;

    localparam int ADC_WIDTH_DEF  = 12;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int NOW_W      = 32;
    localparam int GAIN_W     = 20;
    localparam int MBAR_W     = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int NUM_LANES  = 2;

    // Result word: two pressures and four fault flags, padded to whole bytes.
    localparam int OUT_BITS    = 2 * MBAR_W + 4;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd6;

    localparam logic [GAIN_W-1:0]        GAIN_RST       = 20'd352086;
    localparam logic signed [MBAR_W-1:0] OFFSET_RST     = -16'sd4015;
    localparam logic signed [MBAR_W-1:0] CLAMP_LOW_RST  = -16'sd1900;
    localparam logic signed [MBAR_W-1:0] CLAMP_HIGH_RST = 16'sd17900;
    localparam logic signed [MBAR_W-1:0] UNDER_THR_RST  = -16'sd500;
    localparam logic signed [MBAR_W-1:0] OVER_THR_RST   = 16'sd3000;
    localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST    = 16'd1000;

    typedef struct packed {
        logic [GAIN_W-1:0]        gain;
        logic signed [MBAR_W-1:0] offset;
        logic signed [MBAR_W-1:0] clamp_low;
        logic signed [MBAR_W-1:0] clamp_high;
        logic signed [MBAR_W-1:0] under_thr;
        logic signed [MBAR_W-1:0] over_thr;
        logic [TIMEOUT_W-1:0]     timeout;
    } cfg_t;

    typedef struct packed {
        logic under_ok;
        logic over_ok;
    } lane_ok_t;

endpackage

// File: hw/rtl/dual_pressure_limit_monitor_unit.sv
// Channel  | Handshake          | Payload
// input    | s_tvalid, s_tready | s_tdata: intake_raw, outtake_raw, now_ticks
// result   | m_tvalid, m_tready | m_tdata: pressures and four fault flags
// config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// One word per cycle is accepted while s_tready is high; an accepted word passes
// through the multiplier register, pressure register and output register.
// aresetn is synchronous and active low; it restores the register reset values
// and sets all four ok stamps to zero.
// Each stage moves on when the stage after it is empty or moving, so a stalled
// result does not block words from filling the earlier stages.
module dual_pressure_limit_monitor_unit import dplm_pkg::*; #(
    parameter int ADC_WIDTH  = ADC_WIDTH_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // intake_raw, outtake_raw, now_ticks (from bit 0 up), zero padded
    input  logic [((2 * ADC_WIDTH + NOW_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // intake_mbar, outtake_mbar, intake_under_fault, intake_over_fault,
    // outtake_under_fault, outtake_over_fault (from bit 0 up), zero padded
    output logic [OUT_TDATA_W-1:0]                     m_tdata,
    input  logic                                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                       cfg_index,
    input  logic [CFG_DATA_W-1:0]                      cfg_wdata
);

    cfg_t cfg_reg;

    logic v1_reg, v2_reg, vo_reg;
    logic ld1, ld2, ldo;

    logic [TIME_WIDTH-1:0] now1_reg, now2_reg;

    logic [ADC_WIDTH-1:0]     raw       [NUM_LANES];
    logic signed [MBAR_W-1:0] pressure  [NUM_LANES];
    lane_ok_t                 ok        [NUM_LANES];
    logic                     under_f   [NUM_LANES];
    logic                     over_f    [NUM_LANES];

    logic signed [MBAR_W-1:0] mbar_reg  [NUM_LANES];
    logic                     under_reg [NUM_LANES];
    logic                     over_reg  [NUM_LANES];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain       <= GAIN_RST;
            cfg_reg.offset     <= OFFSET_RST;
            cfg_reg.clamp_low  <= CLAMP_LOW_RST;
            cfg_reg.clamp_high <= CLAMP_HIGH_RST;
            cfg_reg.under_thr  <= UNDER_THR_RST;
            cfg_reg.over_thr   <= OVER_THR_RST;
            cfg_reg.timeout    <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GAIN:       cfg_reg.gain       <= cfg_wdata;
                REG_OFFSET:     cfg_reg.offset     <= cfg_wdata[MBAR_W-1:0];
                REG_CLAMP_LOW:  cfg_reg.clamp_low  <= cfg_wdata[MBAR_W-1:0];
                REG_CLAMP_HIGH: cfg_reg.clamp_high <= cfg_wdata[MBAR_W-1:0];
                REG_UNDER_THR:  cfg_reg.under_thr  <= cfg_wdata[MBAR_W-1:0];
                REG_OVER_THR:   cfg_reg.over_thr   <= cfg_wdata[MBAR_W-1:0];
                REG_TIMEOUT:    cfg_reg.timeout    <= cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    assign ldo      = v2_reg && (!vo_reg || m_tready);
    assign ld2      = v1_reg && (!v2_reg || ldo);
    assign s_tready = !v1_reg || ld2;
    assign ld1      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= 1'b1;
            end else if (ld2) begin
                v1_reg <= 1'b0;
            end
            if (ld2) begin
                v2_reg <= 1'b1;
            end else if (ldo) begin
                v2_reg <= 1'b0;
            end
            if (ldo) begin
                vo_reg <= 1'b1;
            end else if (m_tready) begin
                vo_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            now1_reg <= TIME_WIDTH'(s_tdata[2 * ADC_WIDTH +: NOW_W]);
        end
        if (ld2) begin
            now2_reg <= now1_reg;
        end
    end

    assign raw[0] = s_tdata[0 +: ADC_WIDTH];
    assign raw[1] = s_tdata[ADC_WIDTH +: ADC_WIDTH];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        dplm_lane #(
            .ADC_WIDTH (ADC_WIDTH)
        ) u_lane (
            .aclk     (aclk),
            .ld_prod  (ld1),
            .ld_press (ld2),
            .raw      (raw[g]),
            .cfg      (cfg_reg),
            .pressure (pressure[g]),
            .ok       (ok[g])
        );

        dplm_watch #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_under (
            .aclk    (aclk),
            .aresetn (aresetn),
            .upd     (ldo),
            .ok      (ok[g].under_ok),
            .now     (now2_reg),
            .timeout (cfg_reg.timeout),
            .fault   (under_f[g])
        );

        dplm_watch #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_over (
            .aclk    (aclk),
            .aresetn (aresetn),
            .upd     (ldo),
            .ok      (ok[g].over_ok),
            .now     (now2_reg),
            .timeout (cfg_reg.timeout),
            .fault   (over_f[g])
        );

        always_ff @(posedge aclk) begin
            if (ldo) begin
                mbar_reg[g]  <= pressure[g];
                under_reg[g] <= under_f[g];
                over_reg[g]  <= over_f[g];
            end
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                       over_reg[1], under_reg[1], over_reg[0], under_reg[0],
                       mbar_reg[1], mbar_reg[0]};

endmodule

// File: hw/rtl/dplm_lane.sv
module dplm_lane import dplm_pkg::*; #(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     ld_prod,
    input  logic                     ld_press,
    input  logic [ADC_WIDTH-1:0]     raw,
    input  cfg_t                     cfg,
    output logic signed [MBAR_W-1:0] pressure,
    output lane_ok_t                 ok
);

    localparam int PROD_W = ADC_WIDTH + GAIN_W;
    localparam int RND_W  = PROD_W + 1 - FRAC_W;
    localparam int SUM_W  = ADC_WIDTH + 18;

    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W:0]          prod_half;
    logic [RND_W-1:0]         rnd;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lo_ext;
    logic signed [SUM_W-1:0]  hi_ext;
    logic signed [SUM_W-1:0]  upper_cut;
    logic signed [SUM_W-1:0]  clamped;
    logic signed [MBAR_W-1:0] pressure_reg;
    logic signed [MBAR_W-1:0] pressure_next;

    assign prod_next = PROD_W'(raw) * PROD_W'(cfg.gain);

    // Round half up before dropping the fraction bits.
    assign prod_half = {1'b0, prod_reg} + (PROD_W + 1)'(1 << (FRAC_W - 1));
    assign rnd       = prod_half[PROD_W:FRAC_W];
    assign sum       = $signed({{(SUM_W - RND_W){1'b0}}, rnd}) + SUM_W'(cfg.offset);
    assign lo_ext    = SUM_W'(cfg.clamp_low);
    assign hi_ext    = SUM_W'(cfg.clamp_high);

    // The low limit is applied last, so it wins when the limits cross.
    assign upper_cut     = (sum > hi_ext) ? hi_ext : sum;
    assign clamped       = (upper_cut < lo_ext) ? lo_ext : upper_cut;
    assign pressure_next = MBAR_W'(clamped);

    always_ff @(posedge aclk) begin
        if (ld_prod) begin
            prod_reg <= prod_next;
        end
        if (ld_press) begin
            pressure_reg <= pressure_next;
        end
    end

    assign pressure    = pressure_reg;
    assign ok.under_ok = pressure_reg > cfg.under_thr;
    assign ok.over_ok  = pressure_reg < cfg.over_thr;

endmodule

// File: hw/rtl/dplm_watch.sv
module dplm_watch import dplm_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  upd,
    input  logic                  ok,
    input  logic [TIME_WIDTH-1:0] now,
    input  logic [TIMEOUT_W-1:0]  timeout,
    output logic                  fault
);

    logic [TIME_WIDTH-1:0] stamp_reg;
    logic [TIME_WIDTH-1:0] stamp_next;
    logic [TIME_WIDTH-1:0] elapsed;

    assign stamp_next = ok ? now : stamp_reg;
    assign elapsed    = now - stamp_reg;

    // A good sample refreshes the stamp to now and never raises the fault.
    assign fault = !ok && (elapsed > TIME_WIDTH'(timeout));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg <= '0;
        end else if (upd) begin
            stamp_reg <= stamp_next;
        end
    end

endmodule

// File: hw/rtl/dplm_checker.sv
`include "dual_pressure_limit_monitor_unit_defines.svh"

module dplm_checker import dplm_pkg::*; #(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
    input logic                                               aclk,
    input logic                                               aresetn,
    input logic                                               s_tvalid,
    input logic                                               s_tready,
    input logic [((2 * ADC_WIDTH + NOW_W + 7) / 8) * 8 - 1:0] s_tdata,
    input logic                                               m_tvalid,
    input logic                                               m_tready,
    input logic [OUT_TDATA_W-1:0]                             m_tdata,
    input logic                                               cfg_wr_en,
    input logic [CFG_IDX_W-1:0]                               cfg_index,
    input logic [CFG_DATA_W-1:0]                              cfg_wdata
);

    logic signed [MBAR_W-1:0] lo_reg, hi_reg, under_reg, over_reg;
    logic signed [MBAR_W-1:0] p_in, p_out;
    logic                     in_range_ok, in_under_ok, in_over_ok;
    logic                     out_under_ok, out_over_ok;
    logic                     in_word;

    // Shadow copies of the limits, taken from the configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= CLAMP_LOW_RST;
            hi_reg    <= CLAMP_HIGH_RST;
            under_reg <= UNDER_THR_RST;
            over_reg  <= OVER_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CLAMP_LOW:  lo_reg    <= cfg_wdata[MBAR_W-1:0];
                REG_CLAMP_HIGH: hi_reg    <= cfg_wdata[MBAR_W-1:0];
                REG_UNDER_THR:  under_reg <= cfg_wdata[MBAR_W-1:0];
                REG_OVER_THR:   over_reg  <= cfg_wdata[MBAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_word = s_tvalid && s_tready && (s_tdata != '0 || s_tdata == '0);
    assign p_in    = m_tdata[0 +: MBAR_W];
    assign p_out   = m_tdata[MBAR_W +: MBAR_W];

    assign in_range_ok = (p_in >= lo_reg) && ((p_in <= hi_reg) || (p_in == lo_reg)) &&
                         (p_out >= lo_reg) && ((p_out <= hi_reg) || (p_out == lo_reg));

    // A pressure on the good side of its threshold never carries that fault.
    assign in_under_ok  = !(p_in > under_reg) || !m_tdata[2 * MBAR_W];
    assign in_over_ok   = !(p_in < over_reg) || !m_tdata[2 * MBAR_W + 1];
    assign out_under_ok = !(p_out > under_reg) || !m_tdata[2 * MBAR_W + 2];
    assign out_over_ok  = !(p_out < over_reg) || !m_tdata[2 * MBAR_W + 3];

    `DPLM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `DPLM_ASSERT_NOW(a_clamp_range, aclk, aresetn, m_tvalid, in_range_ok, "pressure outside the clamp limits")
    `DPLM_ASSERT_NOW(a_under_clear, aclk, aresetn, m_tvalid, in_under_ok && out_under_ok, "under fault with pressure above threshold")
    `DPLM_ASSERT_NOW(a_over_clear, aclk, aresetn, m_tvalid || in_word, !m_tvalid || (in_over_ok && out_over_ok), "over fault with pressure below threshold")

endmodule

bind dual_pressure_limit_monitor_unit dplm_checker #(
    .ADC_WIDTH (ADC_WIDTH)
) u_dplm_checker (.*);
